/* design/pftp_pkg.sv */
package pftp_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = 25;
  localparam int SUM_W   = 26;
  localparam int PROD_W  = 50;
  localparam int CROSS_W = 51;
  localparam int MAG_W   = 50;
  localparam int HALF_W  = 25;
  localparam int SQ_W    = 100;
  localparam int RAD_W   = 106;
  localparam int ROOT_W  = 53;
  localparam int REM_W   = 55;
  localparam int FRAC_W  = 30;
  localparam int NORM_W  = 32;
  localparam int THR_W   = 32;
  localparam int DIV_LAT = FRAC_W + 2;

  // floor(x / 3) == (x * DIV3_RECIP) >> DIV3_SHIFT for all x < 2^27
  localparam int DIV3_SHIFT = 27;
  localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP = 27'd44739243;

  localparam logic [THR_W-1:0] THR_RESET = 32'd1000;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic [ROOT_W-1:0]         cross_len;
    logic                      collinear;
  } out_t;

  // word passed from the front to the back through the queue
  typedef struct packed {
    logic signed [CROSS_W-1:0] cross_x;
    logic signed [CROSS_W-1:0] cross_y;
    logic signed [CROSS_W-1:0] cross_z;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
  } mid_t;

  typedef struct packed {
    logic [2:0]                sign;
    logic [MAG_W-1:0]          mag_x;
    logic [MAG_W-1:0]          mag_y;
    logic [MAG_W-1:0]          mag_z;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
  } side_t;

  typedef struct packed {
    logic [2:0]                sign;
    logic [ROOT_W-1:0]         mag;
    logic                      col;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
  } dside_t;

endpackage

/* design/plane_from_three_points_unit.sv */
// channel   ports              handshake
// input     item (in_t)        taken when start && !busy
// config    cfg_wdata          written when cfg_we
// result    result (out_t)     valid for one cycle while done
//
// One item enters per cycle while busy is low; each result passes through the front,
// the queue, the squaring stages, the 53-stage square root and the 32-stage dividers.
// Reset (rst, synchronous) empties the pipeline and loads the threshold with 1000.
// busy rises only when the two-word queue between front and back is full;
// the back half always advances, since results cannot be held off.
module plane_from_three_points_unit import pftp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_t              item,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  output logic             done,
  output out_t             result
);

  logic [THR_W-1:0] thr;
  logic full, push, pop;
  mid_t fword, qword;

  always_ff @(posedge clk) begin
    if (rst) thr <= THR_RESET;
    else if (cfg_we) thr <= cfg_wdata;
  end

  assign busy = full;

  pftp_front u_front (
    .clk(clk), .rst(rst), .take(start && !full), .item(item),
    .en(!full), .push(push), .word(fword)
  );

  pftp_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(fword),
    .full(full), .pop(pop), .rdata(qword)
  );

  pftp_back u_back (
    .clk(clk), .rst(rst), .pop(pop), .word(qword), .thr(thr),
    .done(done), .result(result)
  );

endmodule

/* design/pftp_front.sv */
module pftp_front import pftp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  in_t  item,
  input  logic en,
  output logic push,
  output mid_t word
);

  logic v1, v2, v3;
  logic signed [DIFF_W-1:0] ab [3];
  logic signed [DIFF_W-1:0] ac [3];
  logic signed [SUM_W-1:0]  sum [3];
  logic signed [PROD_W-1:0] pr [6];
  logic [SUM_W+DIV3_SHIFT-1:0] cprod [3];
  logic [2:0] cneg;
  logic [SUM_W-1:0] cx [3];
  logic [SUM_W-1:0] cq [3];
  logic signed [COORD_W-1:0] org [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ab[0] <= DIFF_W'(item.b_x) - DIFF_W'(item.a_x);
      ab[1] <= DIFF_W'(item.b_y) - DIFF_W'(item.a_y);
      ab[2] <= DIFF_W'(item.b_z) - DIFF_W'(item.a_z);
      ac[0] <= DIFF_W'(item.c_x) - DIFF_W'(item.a_x);
      ac[1] <= DIFF_W'(item.c_y) - DIFF_W'(item.a_y);
      ac[2] <= DIFF_W'(item.c_z) - DIFF_W'(item.a_z);
      sum[0] <= SUM_W'(item.a_x) + SUM_W'(item.b_x) + SUM_W'(item.c_x);
      sum[1] <= SUM_W'(item.a_y) + SUM_W'(item.b_y) + SUM_W'(item.c_y);
      sum[2] <= SUM_W'(item.a_z) + SUM_W'(item.b_z) + SUM_W'(item.c_z);
    end
  end

  // round to nearest over 3: (|s| + 1) / 3 with the sign put back
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cx[i] = sum[i][SUM_W-1] ? SUM_W'(0 - sum[i]) + SUM_W'(1) : SUM_W'(sum[i]) + SUM_W'(1);
      cq[i] = cprod[i][SUM_W+DIV3_SHIFT-1:DIV3_SHIFT];
      org[i] = cneg[i] ? COORD_W'(~cq[i] + SUM_W'(1)) : COORD_W'(cq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr[0] <= ab[1] * ac[2];
      pr[1] <= ab[2] * ac[1];
      pr[2] <= ab[2] * ac[0];
      pr[3] <= ab[0] * ac[2];
      pr[4] <= ab[0] * ac[1];
      pr[5] <= ab[1] * ac[0];
      for (int i = 0; i < 3; i++) begin
        cneg[i]  <= sum[i][SUM_W-1];
        cprod[i] <= (SUM_W+DIV3_SHIFT)'(cx[i]) * (SUM_W+DIV3_SHIFT)'(DIV3_RECIP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word.cross_x  <= CROSS_W'(pr[0]) - CROSS_W'(pr[1]);
      word.cross_y  <= CROSS_W'(pr[2]) - CROSS_W'(pr[3]);
      word.cross_z  <= CROSS_W'(pr[4]) - CROSS_W'(pr[5]);
      word.origin_x <= org[0];
      word.origin_y <= org[1];
      word.origin_z <= org[2];
    end
  end

  assign push = v3 && en;

endmodule

/* design/pftp_queue.sv */
module pftp_queue import pftp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  mid_t wdata,
  output logic full,
  output logic pop,
  output mid_t rdata
);

  mid_t slot [2];
  logic wptr, rptr;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign pop   = (cnt != 2'd0);
  assign rdata = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= wdata;
  end

endmodule

/* design/pftp_div.sv */
module pftp_div import pftp_pkg::*; (
  input  logic              clk,
  input  logic [MAG_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic [FRAC_W:0]   quo
);

  logic [ROOT_W:0]   r [0:FRAC_W];
  logic [ROOT_W-1:0] d [0:FRAC_W];
  logic [FRAC_W:0]   q [0:FRAC_W];
  logic [ROOT_W:0]   n_ext;
  logic [ROOT_W+1:0] twor;
  logic [FRAC_W+1:0] qr;

  assign n_ext = (ROOT_W+1)'(num);

  // numerator never exceeds the divisor, so the integer bit is a single compare
  always_ff @(posedge clk) begin
    d[0] <= den;
    if (n_ext >= (ROOT_W+1)'(den)) begin
      r[0] <= n_ext - (ROOT_W+1)'(den);
      q[0] <= (FRAC_W+1)'(1);
    end else begin
      r[0] <= n_ext;
      q[0] <= '0;
    end
  end

  for (genvar j = 0; j < FRAC_W; j++) begin : g_step
    logic [ROOT_W+1:0] rs;
    assign rs = {r[j], 1'b0};
    always_ff @(posedge clk) begin
      d[j+1] <= d[j];
      if (rs >= (ROOT_W+2)'(d[j])) begin
        r[j+1] <= (ROOT_W+1)'(rs - (ROOT_W+2)'(d[j]));
        q[j+1] <= {q[j][FRAC_W-1:0], 1'b1};
      end else begin
        r[j+1] <= (ROOT_W+1)'(rs);
        q[j+1] <= {q[j][FRAC_W-1:0], 1'b0};
      end
    end
  end

  // round half away from zero, clamp to one
  always_comb begin
    twor = {r[FRAC_W], 1'b0};
    qr = (FRAC_W+2)'(q[FRAC_W]) + (FRAC_W+2)'(twor >= (ROOT_W+2)'(d[FRAC_W]));
  end

  always_ff @(posedge clk) begin
    if (qr > (FRAC_W+2)'(1) << FRAC_W) quo <= (FRAC_W+1)'(1) << FRAC_W;
    else quo <= qr[FRAC_W:0];
  end

endmodule

/* design/pftp_back.sv */
module pftp_back import pftp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop,
  input  mid_t             word,
  input  logic [THR_W-1:0] thr,
  output logic             done,
  output out_t             result
);

  logic [MAG_W-1:0] mag [3];
  logic [PROD_W-1:0] hh [3];
  logic [PROD_W-1:0] hl [3];
  logic [PROD_W-1:0] ll [3];
  logic [SQ_W-1:0] sq [3];
  side_t s1, s2;
  logic v1, v2;

  logic [RAD_W-1:0]  rad  [0:ROOT_W];
  logic [REM_W-1:0]  rem  [0:ROOT_W];
  logic [ROOT_W-1:0] root [0:ROOT_W];
  side_t             sd   [0:ROOT_W];
  logic              vld  [0:ROOT_W];

  dside_t dl  [0:DIV_LAT-1];
  logic   dv  [0:DIV_LAT-1];
  dside_t din;
  logic [FRAC_W:0] quo [3];

  always_comb begin
    mag[0] = word.cross_x[CROSS_W-1] ? MAG_W'(-word.cross_x) : MAG_W'(word.cross_x);
    mag[1] = word.cross_y[CROSS_W-1] ? MAG_W'(-word.cross_y) : MAG_W'(word.cross_y);
    mag[2] = word.cross_z[CROSS_W-1] ? MAG_W'(-word.cross_z) : MAG_W'(word.cross_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vld[0] <= 1'b0;
    end else begin
      v1 <= pop;
      v2 <= v1;
      vld[0] <= v2;
    end
  end

  // square each component from half-width partial products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      hh[i] <= mag[i][MAG_W-1:HALF_W] * mag[i][MAG_W-1:HALF_W];
      hl[i] <= mag[i][MAG_W-1:HALF_W] * mag[i][HALF_W-1:0];
      ll[i] <= mag[i][HALF_W-1:0] * mag[i][HALF_W-1:0];
    end
    s1.sign     <= {word.cross_z[CROSS_W-1], word.cross_y[CROSS_W-1], word.cross_x[CROSS_W-1]};
    s1.mag_x    <= mag[0];
    s1.mag_y    <= mag[1];
    s1.mag_z    <= mag[2];
    s1.origin_x <= word.origin_x;
    s1.origin_y <= word.origin_y;
    s1.origin_z <= word.origin_z;
    for (int i = 0; i < 3; i++) begin
      sq[i] <= (SQ_W'(hh[i]) << (2 * HALF_W)) + (SQ_W'(hl[i]) << (HALF_W + 1)) + SQ_W'(ll[i]);
    end
    s2 <= s1;
    rad[0]  <= RAD_W'(sq[0] + sq[1] + sq[2]);
    rem[0]  <= '0;
    root[0] <= '0;
    sd[0]   <= s2;
  end

  // one root bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W+1:0] rn, tr;
    assign rn = {rem[k], rad[k][RAD_W-1 -: 2]};
    assign tr = (REM_W+2)'({root[k], 2'b01});
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else vld[k+1] <= vld[k];
    end
    always_ff @(posedge clk) begin
      rad[k+1] <= rad[k] << 2;
      sd[k+1]  <= sd[k];
      if (rn >= tr) begin
        rem[k+1]  <= REM_W'(rn - tr);
        root[k+1] <= {root[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem[k+1]  <= REM_W'(rn);
        root[k+1] <= {root[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    din.sign     = sd[ROOT_W].sign;
    din.mag      = root[ROOT_W];
    din.col      = (root[ROOT_W] == '0) || (root[ROOT_W] < ROOT_W'(thr));
    din.origin_x = sd[ROOT_W].origin_x;
    din.origin_y = sd[ROOT_W].origin_y;
    din.origin_z = sd[ROOT_W].origin_z;
  end

  pftp_div u_div_x (.clk(clk), .num(sd[ROOT_W].mag_x), .den(root[ROOT_W]), .quo(quo[0]));
  pftp_div u_div_y (.clk(clk), .num(sd[ROOT_W].mag_y), .den(root[ROOT_W]), .quo(quo[1]));
  pftp_div u_div_z (.clk(clk), .num(sd[ROOT_W].mag_z), .den(root[ROOT_W]), .quo(quo[2]));

  // hold item info alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DIV_LAT; j++) dv[j] <= 1'b0;
      done <= 1'b0;
    end else begin
      dv[0] <= vld[ROOT_W];
      for (int j = 1; j < DIV_LAT; j++) dv[j] <= dv[j-1];
      done <= dv[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    dl[0] <= din;
    for (int j = 1; j < DIV_LAT; j++) dl[j] <= dl[j-1];
  end

  always_ff @(posedge clk) begin
    result.normal_x <= dl[DIV_LAT-1].col ? '0 :
      (dl[DIV_LAT-1].sign[0] ? -NORM_W'(quo[0]) : NORM_W'(quo[0]));
    result.normal_y <= dl[DIV_LAT-1].col ? '0 :
      (dl[DIV_LAT-1].sign[1] ? -NORM_W'(quo[1]) : NORM_W'(quo[1]));
    result.normal_z <= dl[DIV_LAT-1].col ? '0 :
      (dl[DIV_LAT-1].sign[2] ? -NORM_W'(quo[2]) : NORM_W'(quo[2]));
    result.origin_x  <= dl[DIV_LAT-1].origin_x;
    result.origin_y  <= dl[DIV_LAT-1].origin_y;
    result.origin_z  <= dl[DIV_LAT-1].origin_z;
    result.cross_len <= dl[DIV_LAT-1].mag;
    result.collinear <= dl[DIV_LAT-1].col;
  end

endmodule

/* sim/plane_from_three_points_unit_tb.sv */
module plane_from_three_points_unit_tb;
  import pftp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 3 + 1 + 3 + 53 + 32 + 1;
  localparam int N_RANDOM = 400;
  localparam int N_TABLE = 14;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  in_t              item = '0;
  logic             cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_wdata = '0;
  logic             done;
  out_t             result;

  plane_from_three_points_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [THR_W-1:0] threshold;
  out_t             plane_q[$];
  int               mismatches = 0;

  // exact floor square root of a sum of squares
  function automatic logic [ROOT_W-1:0] floor_root(logic [RAD_W-1:0] s);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] c;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      c = r | (53'd1 << b);
      if ({53'd0, c} * {53'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [NORM_W-1:0] unit_comp(logic signed [63:0] c,
                                                        logic [ROOT_W-1:0] m);
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] rem;
    num = (c < 0 ? -c : c);
    num = num << FRAC_W;
    q = num / m;
    rem = num % m;
    if (rem >= m - rem) q = q + 1;
    if (q > (128'd1 << FRAC_W)) q = 128'd1 << FRAC_W;
    return c < 0 ? -$signed(q[NORM_W-1:0]) : $signed(q[NORM_W-1:0]);
  endfunction

  function automatic logic signed [COORD_W-1:0] centroid_of(logic signed [63:0] s);
    logic signed [63:0] r;
    if (s >= 0) r = (s + 1) / 3;
    else r = -((-s + 1) / 3);
    return r[COORD_W-1:0];
  endfunction

  function automatic out_t plane_of(in_t p);
    logic signed [63:0] pa[3], pb[3], pc[3], ab[3], ac[3], cr[3];
    logic [RAD_W-1:0]   sq;
    out_t               o;
    pa = '{p.a_x, p.a_y, p.a_z};
    pb = '{p.b_x, p.b_y, p.b_z};
    pc = '{p.c_x, p.c_y, p.c_z};
    for (int i = 0; i < 3; i++) begin
      ab[i] = pb[i] - pa[i];
      ac[i] = pc[i] - pa[i];
    end
    cr[0] = ab[1] * ac[2] - ab[2] * ac[1];
    cr[1] = ab[2] * ac[0] - ab[0] * ac[2];
    cr[2] = ab[0] * ac[1] - ab[1] * ac[0];
    sq = '0;
    for (int i = 0; i < 3; i++)
      sq = sq + RAD_W'(128'($signed(cr[i])) * 128'($signed(cr[i])));
    o = '0;
    o.cross_len = floor_root(sq);
    o.collinear = (o.cross_len == 0) || (o.cross_len < {21'd0, threshold});
    if (!o.collinear) begin
      o.normal_x = unit_comp(cr[0], o.cross_len);
      o.normal_y = unit_comp(cr[1], o.cross_len);
      o.normal_z = unit_comp(cr[2], o.cross_len);
    end
    o.origin_x = centroid_of(pa[0] + pb[0] + pc[0]);
    o.origin_y = centroid_of(pa[1] + pb[1] + pc[1]);
    o.origin_z = centroid_of(pa[2] + pb[2] + pc[2]);
    return o;
  endfunction

  // check every result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (plane_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        out_t want;
        want = plane_q.pop_front();
        if (result !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, result);
        end
      end
    end
  end

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_points(in_t p, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(8) : 0;
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      wait_cycles(gap);
    end
    item <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    plane_q.insert(plane_q.size(), plane_of(p));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (plane_q.size() != 0) @(posedge clk);
    wait_cycles(4);
  endtask

  task automatic set_threshold(logic [THR_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold = v;
  endtask

  function automatic logic signed [COORD_W-1:0] rnd_coord(int mode);
    case (mode)
      0: return COORD_W'($urandom);
      1: return COORD_W'($signed($urandom_range(200)) - 100);
      2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      default: return COORD_W'($signed($urandom_range(20000)) - 10000);
    endcase
  endfunction

  function automatic in_t random_points();
    in_t p;
    int  mode;
    logic signed [COORD_W-1:0] dx, dy, dz;
    int  k;
    mode = $urandom_range(3);
    p.a_x = rnd_coord(mode); p.a_y = rnd_coord(mode); p.a_z = rnd_coord(mode);
    p.b_x = rnd_coord(mode); p.b_y = rnd_coord(mode); p.b_z = rnd_coord(mode);
    p.c_x = rnd_coord(mode); p.c_y = rnd_coord(mode); p.c_z = rnd_coord(mode);
    if ($urandom_range(5) == 0) begin
      // make C lie on line AB, with a small nudge now and then
      dx = $signed($urandom_range(2000)) - 1000;
      dy = $signed($urandom_range(2000)) - 1000;
      dz = $signed($urandom_range(2000)) - 1000;
      k = $urandom_range(4);
      p.b_x = p.a_x + dx; p.b_y = p.a_y + dy; p.b_z = p.a_z + dz;
      p.c_x = p.a_x + k * dx + $signed($urandom_range(2)) - 1;
      p.c_y = p.a_y + k * dy; p.c_z = p.a_z + k * dz;
    end
    return p;
  endfunction

  in_t points_table[N_TABLE];
  logic [THR_W-1:0] thr_list[5] = '{32'd0, 32'hFFFFFFFF, 32'd1, 32'd1000000, 32'd1000};

  initial begin
    // degenerate, extreme and simple planes
    points_table[0]  = '0;
    points_table[1]  = '{0, 0, 0, 1000, 0, 0, 0, 1000, 0};
    points_table[2]  = '{0, 0, 0, 0, 1000, 0, 1000, 0, 0};
    points_table[3]  = '{0, 0, 0, 0, 0, 1000, 1000, 0, 0};
    points_table[4]  = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
                         24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF};
    points_table[5]  = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                         24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh800000};
    points_table[6]  = '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                         24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF};
    points_table[7]  = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
    points_table[8]  = '{0, 0, 0, 31, 0, 0, 0, 32, 0};
    points_table[9]  = '{0, 0, 0, 32, 0, 0, 0, 32, 0};
    points_table[10] = '{-1, -1, -1, -1, -1, -1, -2, -2, -2};
    points_table[11] = '{5, -7, 11, 8000, 3, -9, -2, 6000, 40};
    points_table[12] = '{24'sh7FFFFF, 0, 0, 0, 24'sh7FFFFF, 0, 0, 0, 24'sh7FFFFF};
    points_table[13] = '{-100, 50, 0, 300, -20, 1, 7, 7, -900};

    threshold = THR_RESET;
    wait_cycles(9);
    rst <= 1'b0;
    @(posedge clk);

    foreach (points_table[i]) send_points(points_table[i], 1'b0);
    drain();
    foreach (thr_list[t]) begin
      set_threshold(thr_list[t]);
      for (int i = 0; i < N_TABLE; i++) send_points(points_table[i], 1'b1);
      for (int i = 0; i < N_RANDOM / 5; i++)
        send_points(random_points(), (i / 25) % 2 == 1);
      drain();
    end
    set_threshold($urandom);
    for (int i = 0; i < 40; i++) send_points(random_points(), 1'b1);
    drain();
    wait_cycles(LATENCY);

    if (mismatches == 0 && plane_q.size() == 0)
      $display("plane_from_three_points_unit_tb OK");
    else
      $display("plane_from_three_points_unit_tb NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("plane_from_three_points_unit_tb NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
design/pftp_pkg.sv
design/pftp_front.sv
design/pftp_queue.sv
design/pftp_div.sv
design/pftp_back.sv
design/plane_from_three_points_unit.sv
sim/plane_from_three_points_unit_tb.sv
